// File: rtl/cbq_pkg.sv
// Shared types, constants, coefficient table and helpers of the cascaded biquad filter.
package cbq_pkg;

  // Parameter defaults and limits
  localparam int NUM_SECTIONS_DEF   = 9;
  localparam int COEF_FRAC_BITS_DEF = 22;
  localparam int MAX_SECTIONS       = 16;
  localparam int SEC_IDX_W          = 4;

  // Data formats: samples Q1.15, internal signals Q12.20, table Q2.22
  localparam int SAMPLE_W = 16;
  localparam int SIG_W    = 32;
  localparam int SIG_FRAC = 20;
  localparam int ROM_W    = 24;
  localparam int ROM_FRAC = 22;
  // Largest table magnitude is below 2^23, so a shift of up to eight stays in 32 bits
  localparam int COEF_W   = 32;
  localparam int PROD_W   = COEF_W + SIG_W;
  localparam int ACC_W    = 64;

  typedef struct packed {
    logic signed [ROM_W-1:0] g;
    logic signed [ROM_W-1:0] a1;
    logic signed [ROM_W-1:0] a2;
    logic signed [ROM_W-1:0] b1;
    logic signed [ROM_W-1:0] b2;
  } coef_set_t;

  localparam logic signed [ROM_W-1:0] ONE_Q22 = 24'sd4194304;

  // Section coefficients; sections beyond the ninth pass their input through
  localparam coef_set_t COEF_ROM [MAX_SECTIONS] = '{
    '{ 24'sd2205485, -24'sd8359889, 24'sd4182745, -24'sd8373168, ONE_Q22},
    '{ 24'sd4131993, -24'sd8248215, 24'sd4075524, -24'sd8378531, ONE_Q22},
    '{ 24'sd7507566, -24'sd3712798, 24'sd0,       -ONE_Q22,      24'sd0},
    '{ 24'sd3273846, -24'sd8323771, 24'sd4187882, -24'sd8331592, ONE_Q22},
    '{ 24'sd3273846, -24'sd8332133, 24'sd4188332, -24'sd8336789, ONE_Q22},
    '{ 24'sd6826301, -24'sd8276275, 24'sd4135949, -24'sd8334252, ONE_Q22},
    '{ 24'sd3273846, -24'sd8157513, 24'sd4187996, -24'sd8166437, ONE_Q22},
    '{ 24'sd3273846, -24'sd8173457, 24'sd4188218, -24'sd8176766, ONE_Q22},
    '{ 24'sd6826301, -24'sd8114816, 24'sd4135949, -24'sd8171662, ONE_Q22},
    '{ ONE_Q22, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
    '{ ONE_Q22, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
    '{ ONE_Q22, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
    '{ ONE_Q22, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
    '{ ONE_Q22, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
    '{ ONE_Q22, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
    '{ ONE_Q22, 24'sd0, 24'sd0, 24'sd0, 24'sd0}
  };

  // Rescale a table entry to the chosen number of fraction bits (round half up)
  function automatic logic signed [COEF_W-1:0] coef_scale(input logic signed [ROM_W-1:0] c,
                                                           input int cfb);
    logic signed [63:0] wide;
    wide = 64'(c);
    if (cfb >= ROM_FRAC) begin
      wide = wide <<< (cfb - ROM_FRAC);
    end else begin
      wide = (wide + (64'sd1 <<< (ROM_FRAC - cfb - 1))) >>> (ROM_FRAC - cfb);
    end
    return COEF_W'(wide);
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_G,
    ST_A1,
    ST_A2,
    ST_B1,
    ST_B2,
    ST_Y,
    ST_X,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    COEF_G,
    COEF_A1,
    COEF_A2,
    COEF_B1,
    COEF_B2
  } coef_sel_t;

  typedef enum logic [1:0] {
    SIG_X,
    SIG_RD,
    SIG_W1,
    SIG_W2
  } sig_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB,
    ACC_ADD_W,
    ACC_ADD
  } acc_op_t;

  typedef enum logic {
    WORD_W1,
    WORD_W2
  } word_t;

  typedef struct packed {
    logic                 load_in;
    logic [SEC_IDX_W-1:0] sec;
    logic                 rd_en;
    word_t                rd_word;
    logic                 cap_w1;
    logic                 cap_w2;
    logic                 mul_en;
    coef_sel_t            coef_sel;
    sig_sel_t             sig_sel;
    acc_op_t              acc_op;
    logic                 wr_en;
    word_t                wr_word;
    logic                 x_update;
    logic                 out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: rtl/cascaded_biquad_iir_filter.sv
// Top level of the cascaded biquad IIR filter: sequencer plus datapath.
//
// Filters signed Q1.15 samples through NUM_SECTIONS direct-form-II sections
// (eight second order, the third first order) with one sample in flight at a
// time. A sample's result is loaded into the output register after its last
// section, and a new sample is not accepted before that load: every section
// steps through the states G, A1, A2, B1, B2, Y and X on one shared 32x32
// multiplier doing five products, with the two delay words read through the
// single read port of the delay RAM. A new sample is accepted the cycle after
// the previous result has been loaded into the output register, even while
// that result still waits to be taken; the sequencer then holds its finished
// result until the output register is free, so output stalls delay both the
// load and the acceptance of the next sample. The delay words are marked
// unwritten at reset and read as zero until first written, so no clearing pass
// is needed. Internal signals are Q12.20 and saturate per section; the
// saturated flag reports clipping of the final 16-bit output only.
module cascaded_biquad_iir_filter #(
  parameter int NUM_SECTIONS   = cbq_pkg::NUM_SECTIONS_DEF,
  parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cbq_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                saturated
);
  import cbq_pkg::*;

  cmd_t    cmd;
  status_t status;

  cbq_ctrl #(
    .NUM_SECTIONS(NUM_SECTIONS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  cbq_datapath #(
    .NUM_SECTIONS  (NUM_SECTIONS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .saturated (saturated)
  );

endmodule

// File: rtl/cbq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module cbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 18
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/cbq_ctrl.sv
// Sequencer that steps the shared multiply-accumulate datapath through each section.
module cbq_ctrl #(
  parameter int NUM_SECTIONS = cbq_pkg::NUM_SECTIONS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cbq_pkg::status_t status,
  output cbq_pkg::cmd_t    cmd
);
  import cbq_pkg::*;

  localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(NUM_SECTIONS - 1);

  state_t           state, state_next;
  logic [SEC_W-1:0] sec, sec_next;
  logic             in_take;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // State and section counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sec   <= '0;
    end else begin
      state <= state_next;
      sec   <= sec_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    sec_next   = sec;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_G;
          sec_next   = '0;
        end
      end
      ST_G:  state_next = ST_A1;
      ST_A1: state_next = ST_A2;
      ST_A2: state_next = ST_B1;
      ST_B1: state_next = ST_B2;
      ST_B2: state_next = ST_Y;
      ST_Y:  state_next = ST_X;
      ST_X: begin
        if (sec == LAST_SEC) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_G;
          sec_next   = sec + SEC_W'(1);
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd          = '0;
    cmd.sec      = SEC_IDX_W'(sec);
    cmd.rd_word  = WORD_W1;
    cmd.wr_word  = WORD_W1;
    cmd.coef_sel = COEF_G;
    cmd.sig_sel  = SIG_X;
    cmd.acc_op   = ACC_HOLD;
    unique case (state)
      ST_IDLE: begin
        cmd.load_in = in_take;
      end
      ST_G: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_word  = WORD_W1;
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_G;
        cmd.sig_sel  = SIG_X;
      end
      ST_A1: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_word  = WORD_W2;
        cmd.cap_w1   = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_A1;
        cmd.sig_sel  = SIG_RD;
        cmd.acc_op   = ACC_LOAD;
      end
      ST_A2: begin
        cmd.cap_w2   = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_A2;
        cmd.sig_sel  = SIG_RD;
        cmd.acc_op   = ACC_SUB;
      end
      ST_B1: begin
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_B1;
        cmd.sig_sel  = SIG_W1;
        cmd.acc_op   = ACC_SUB;
      end
      ST_B2: begin
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_B2;
        cmd.sig_sel  = SIG_W2;
        cmd.acc_op   = ACC_ADD_W;
        cmd.wr_en    = 1'b1;
        cmd.wr_word  = WORD_W2;
      end
      ST_Y: begin
        cmd.acc_op  = ACC_ADD;
        cmd.wr_en   = 1'b1;
        cmd.wr_word = WORD_W1;
      end
      ST_X: begin
        cmd.x_update = 1'b1;
      end
      ST_OUT: begin
        cmd.out_load = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/cbq_datapath.sv
// Datapath: delay store, shared multiplier, accumulator and output register.
module cbq_datapath #(
  parameter int NUM_SECTIONS   = cbq_pkg::NUM_SECTIONS_DEF,
  parameter int COEF_FRAC_BITS = cbq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cbq_pkg::cmd_t                        cmd,
  output cbq_pkg::status_t                     status,
  input  logic signed [cbq_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cbq_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                 saturated
);
  import cbq_pkg::*;

  localparam int DEPTH  = 2 * NUM_SECTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IN_SHIFT  = SIG_FRAC - (SAMPLE_W - 1);
  localparam int OUT_W     = SIG_W + 1 - IN_SHIFT;
  localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_W'(2 ** (SAMPLE_W - 1));

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(SIG_MAX)) begin
      return SIG_MAX;
    end else if (v < ACC_W'(SIG_MIN)) begin
      return SIG_MIN;
    end
    return SIG_W'(v);
  endfunction

  logic signed [SIG_W-1:0]  x_reg, w1_reg, w2_reg, w_reg;
  logic signed [COEF_W-1:0] coef_op;
  logic signed [SIG_W-1:0]  sig_op;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   prod_biased;
  logic signed [ACC_W-1:0]  prod_rnd;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SIG_W-1:0]  acc_sat;
  logic [DEPTH-1:0]         written;
  logic                     rd_valid;
  logic [SIG_W-1:0]         rd_data;
  logic signed [SIG_W-1:0]  rd_word;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic [SIG_W-1:0]         wr_data;
  coef_set_t                coefs;
  logic signed [SIG_W:0]    out_biased;
  logic signed [OUT_W-1:0]  out_round;

  // Delay store addressing: entry 2k is w1, entry 2k+1 is w2
  assign rd_addr = ADDR_W'({cmd.sec, cmd.rd_word == WORD_W2});
  assign wr_addr = ADDR_W'({cmd.sec, cmd.wr_word == WORD_W2});
  assign wr_data = (cmd.wr_word == WORD_W2) ? w1_reg : w_reg;

  cbq_ram #(
    .WIDTH(SIG_W),
    .DEPTH(DEPTH)
  ) u_delay_ram (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Track which delay words hold data; unwritten words read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid <= written[rd_addr];
      end
    end
  end

  assign rd_word = rd_valid ? $signed(rd_data) : '0;

  // Operand selection
  assign coefs = COEF_ROM[cmd.sec];
  always_comb begin
    unique case (cmd.coef_sel)
      COEF_G:  coef_op = coef_scale(coefs.g,  COEF_FRAC_BITS);
      COEF_A1: coef_op = coef_scale(coefs.a1, COEF_FRAC_BITS);
      COEF_A2: coef_op = coef_scale(coefs.a2, COEF_FRAC_BITS);
      COEF_B1: coef_op = coef_scale(coefs.b1, COEF_FRAC_BITS);
      COEF_B2: coef_op = coef_scale(coefs.b2, COEF_FRAC_BITS);
      default: coef_op = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.sig_sel)
      SIG_X:   sig_op = x_reg;
      SIG_RD:  sig_op = rd_word;
      SIG_W1:  sig_op = w1_reg;
      SIG_W2:  sig_op = w2_reg;
      default: sig_op = '0;
    endcase
  end

  // Shared multiplier, registered product
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= coef_op * sig_op;
    end
  end

  // Round product half up to the signal format
  assign prod_biased = (PROD_W+1)'(prod) + ((PROD_W+1)'(1) <<< (COEF_FRAC_BITS - 1));
  assign prod_rnd    = ACC_W'(prod_biased >>> COEF_FRAC_BITS);
  assign acc_sat     = sat_sig(acc);

  // Accumulate and hold signal registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_reg <= SIG_W'(sample_in) <<< IN_SHIFT;
    end else if (cmd.x_update) begin
      x_reg <= acc_sat;
    end
    if (cmd.cap_w1) begin
      w1_reg <= rd_word;
    end
    if (cmd.cap_w2) begin
      w2_reg <= rd_word;
    end
    unique case (cmd.acc_op)
      ACC_HOLD:  acc <= acc;
      ACC_LOAD:  acc <= prod_rnd;
      ACC_SUB:   acc <= acc - prod_rnd;
      ACC_ADD_W: begin
        w_reg <= acc_sat;
        acc   <= ACC_W'(acc_sat) + prod_rnd;
      end
      ACC_ADD:   acc <= acc + prod_rnd;
      default:   acc <= acc;
    endcase
  end

  // Round to Q1.15 and clip
  assign out_biased = (SIG_W+1)'(x_reg) + ((SIG_W+1)'(1) <<< (IN_SHIFT - 1));
  assign out_round  = OUT_W'(out_biased >>> IN_SHIFT);

  // Output register: load a finished transaction, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (out_round > OUT_MAX) begin
        sample_out <= SAMPLE_W'(OUT_MAX);
        saturated  <= 1'b1;
      end else if (out_round < OUT_MIN) begin
        sample_out <= SAMPLE_W'(OUT_MIN);
        saturated  <= 1'b1;
      end else begin
        sample_out <= SAMPLE_W'(out_round);
        saturated  <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule

// File: rtl/cbq_checker.sv
// Port-level assertions for the cascaded biquad filter, bound to the top level.
module cbq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [cbq_pkg::SAMPLE_W-1:0] sample_in,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [cbq_pkg::SAMPLE_W-1:0] sample_out,
  input logic                                saturated
);
  import cbq_pkg::*;

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // One sample in flight: a taken transaction makes the input busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input ready again right after a transaction");

  // A clipped result sits at one of the range limits
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      sample_out == 16'sh7fff || sample_out == 16'sh8000)
    else $error("saturated flag with an in-range sample");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(saturated))
    else $error("stalled result changed");

endmodule

bind cascaded_biquad_iir_filter cbq_checker u_cbq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .sample_in (sample_in),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .sample_out(sample_out),
  .saturated (saturated)
);
